// ===== rtl/spg_pkg.sv =====
`default_nettype none
package spg_pkg;
    localparam int COMPONENT_WIDTH = 16;
    localparam int TIME_WIDTH = 32;
    localparam int NUM_REGS = 6;
    localparam logic [2:0] REG_BASE_POS = 3'd0;
    localparam logic [2:0] REG_BASE_ATT = 3'd1;
    localparam logic [2:0] REG_POS_SWING = 3'd2;
    localparam logic [2:0] REG_POS_RATE = 3'd3;
    localparam logic [2:0] REG_ATT_SWING = 3'd4;
    localparam logic [2:0] REG_ATT_RATE = 3'd5;
    localparam logic signed [32:0] SIN_A = 33'sd1686629713;
    localparam logic signed [32:0] SIN_B = 33'sd688904866;
    localparam logic signed [32:0] SIN_C = 33'sd76016977;
    // sine stage count inside one cell pipeline
    localparam int SIN_STAGES = 5;

    // round to nearest, ties away from zero, by 2^30
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] p);
        logic signed [63:0] a;
        logic signed [63:0] r;
        begin
            a = p[63] ? -p : p;
            r = (a + 64'sd536870912) >>> 30;
            rnd30 = p[63] ? -r : r;
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/spg_sine.sv =====
`default_nettype none
// Pipelined quarter-wave polynomial sine, at most one multiply per stage.
module spg_sine (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [31:0]         i_phase,
    output logic signed [31:0]       o_sin
);
    logic signed [31:0] r_z1, r_z2, r_z3, r_z4, r_zz, r_zz3, r_t1, r_t2, r_t3;
    logic               r_n1, r_n2, r_n3, r_n4;
    logic signed [63:0] n_m;
    logic signed [31:0] n_z;
    logic signed [63:0] w_p1, w_p2, w_p3;

    always_comb begin
        n_z = {2'b00, i_phase[29:0]};
        if (i_phase[30]) n_z = 32'sh4000_0000 - n_z;
        n_m = 64'(n_z) * 64'(n_z);
        w_p1 = 64'(r_zz) * 64'(spg_pkg::SIN_C);
        w_p2 = 64'(r_zz3) * 64'(r_t1);
        w_p3 = 64'(r_z4) * 64'(r_t3);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z1 <= n_z;
            r_n1 <= i_phase[31];
            r_zz <= 32'(n_m >>> 30);
            r_z2 <= r_z1; r_n2 <= r_n1; r_zz3 <= r_zz;
            r_t1 <= 32'(64'(spg_pkg::SIN_B) - (w_p1 >>> 30));
            r_z3 <= r_z2; r_n3 <= r_n2;
            r_t2 <= 32'(64'(spg_pkg::SIN_A) - (w_p2 >>> 30));
            r_z4 <= r_z3; r_n4 <= r_n3; r_t3 <= r_t2;
            o_sin <= r_n4 ? -32'(w_p3 >>> 30) : 32'(w_p3 >>> 30);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/spg_axis_cell.sv =====
`default_nettype none
// One axis: phase, sine, scaled offset added to base.
module spg_axis_cell #(
    parameter int COMPONENT_WIDTH = spg_pkg::COMPONENT_WIDTH,
    parameter int TIME_WIDTH = spg_pkg::TIME_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [TIME_WIDTH-1:0]         i_time,
    input  wire logic [COMPONENT_WIDTH-1:0]    i_rate,
    input  wire logic [COMPONENT_WIDTH-1:0]    i_amp,
    input  wire logic [COMPONENT_WIDTH-1:0]    i_base,
    output logic signed [COMPONENT_WIDTH+1:0]  o_sum
);
    localparam int D = spg_pkg::SIN_STAGES + 1;
    logic [31:0]               r_phase;
    logic signed [31:0]        w_s;
    logic signed [63:0]        w_prod;
    logic [COMPONENT_WIDTH-1:0] r_amp [D];
    logic [COMPONENT_WIDTH-1:0] r_base [D];
    logic [COMPONENT_WIDTH+TIME_WIDTH-1:0] w_rt;

    assign w_rt = (COMPONENT_WIDTH+TIME_WIDTH)'(i_rate) * (COMPONENT_WIDTH+TIME_WIDTH)'(i_time);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phase <= {w_rt[23:0], 8'h00};
            r_amp[0] <= i_amp;
            r_base[0] <= i_base;
            for (int k = 1; k < D; k++) begin
                r_amp[k] <= r_amp[k-1];
                r_base[k] <= r_base[k-1];
            end
        end
    end

    spg_sine u_sin (.i_clk(i_clk), .i_en(i_en), .i_phase(r_phase), .o_sin(w_s));

    assign w_prod = 64'($signed(r_amp[D-1])) * 64'(w_s);

    always_ff @(posedge i_clk) begin
        if (i_en)
            o_sum <= (COMPONENT_WIDTH+2)'($signed(r_base[D-1]))
                   + (COMPONENT_WIDTH+2)'(spg_pkg::rnd30(w_prod));
    end
endmodule
`default_nettype wire

// ===== rtl/sinusoidal_pose_generator_unit.sv =====
`default_nettype none
// Sinusoidal pose generator.
// Input channel: i_time_ticks with i_valid / o_stall. One transaction per
// time stamp. Output channel: nine Q1.15 rotation entries and three
// translations with o_valid / i_stall.
// Configuration: i_cfg_we, i_cfg_index (0..5), i_cfg_data; write only while
// idle. Unknown indexes are ignored.
// Throughput: one transaction per cycle while no valid result is stalled.
// The path runs through the axis cells (phase multiply, five-stage sine,
// scale) and then the angle sine/cosine cells and three matrix product stages.
// Reset clears the config registers and the valid chain. When the receiver
// stalls a valid result, the whole pipeline holds and o_stall rises; no result is lost.
module sinusoidal_pose_generator_unit #(
    parameter int COMPONENT_WIDTH = spg_pkg::COMPONENT_WIDTH,
    parameter int TIME_WIDTH = spg_pkg::TIME_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [TIME_WIDTH-1:0]             i_time_ticks,
    input  wire logic                              i_cfg_we,
    input  wire logic [2:0]                        i_cfg_index,
    input  wire logic [47:0]                       i_cfg_data,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [COMPONENT_WIDTH-1:0]      o_rot_00,
    output logic signed [COMPONENT_WIDTH-1:0]      o_rot_01,
    output logic signed [COMPONENT_WIDTH-1:0]      o_rot_02,
    output logic signed [COMPONENT_WIDTH-1:0]      o_rot_10,
    output logic signed [COMPONENT_WIDTH-1:0]      o_rot_11,
    output logic signed [COMPONENT_WIDTH-1:0]      o_rot_12,
    output logic signed [COMPONENT_WIDTH-1:0]      o_rot_20,
    output logic signed [COMPONENT_WIDTH-1:0]      o_rot_21,
    output logic signed [COMPONENT_WIDTH-1:0]      o_rot_22,
    output logic signed [COMPONENT_WIDTH-1:0]      o_pos_x,
    output logic signed [COMPONENT_WIDTH-1:0]      o_pos_y,
    output logic signed [COMPONENT_WIDTH-1:0]      o_pos_z
);
    localparam int W = COMPONENT_WIDTH;
    localparam int LAT = 15;
    localparam logic signed [W+1:0] HI = (W+2)'((1 << (W-1)) - 1);
    localparam logic signed [W+1:0] LO = -(W+2)'(1 << (W-1));
    localparam logic signed [63:0] EHALF = 64'sd1 <<< (30 - W);

    logic [47:0] r_reg [spg_pkg::NUM_REGS];
    logic [LAT-1:0] r_vld;
    logic en;

    // pipeline moves unless a finished result is blocked
    assign en = !(o_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < spg_pkg::NUM_REGS; k++) r_reg[k] <= '0;
            r_vld <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index < 3'(spg_pkg::NUM_REGS))
                r_reg[i_cfg_index] <= i_cfg_data;
            if (en) r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    logic signed [W+1:0] w_psum [3];
    logic signed [W+1:0] w_asum [3];
    logic signed [31:0]  w_sn [3];
    logic signed [31:0]  w_cs [3];
    logic signed [W+1:0] r_p1 [3], r_p2 [3], r_p3 [3], r_p4 [3], r_p5 [3], r_p6 [3];
    logic signed [W+1:0] r_p7 [3];

    for (genvar g = 0; g < 3; g++) begin : g_ax
        logic [31:0] w_a32;
        spg_axis_cell #(.COMPONENT_WIDTH(W), .TIME_WIDTH(TIME_WIDTH)) u_pos (
            .i_clk(i_clk), .i_en(en), .i_time(i_time_ticks),
            .i_rate(r_reg[spg_pkg::REG_POS_RATE][g*W +: W]),
            .i_amp(r_reg[spg_pkg::REG_POS_SWING][g*W +: W]),
            .i_base(r_reg[spg_pkg::REG_BASE_POS][g*W +: W]),
            .o_sum(w_psum[g]));
        spg_axis_cell #(.COMPONENT_WIDTH(W), .TIME_WIDTH(TIME_WIDTH)) u_att (
            .i_clk(i_clk), .i_en(en), .i_time(i_time_ticks),
            .i_rate(r_reg[spg_pkg::REG_ATT_RATE][g*W +: W]),
            .i_amp(r_reg[spg_pkg::REG_ATT_SWING][g*W +: W]),
            .i_base(r_reg[spg_pkg::REG_BASE_ATT][g*W +: W]),
            .o_sum(w_asum[g]));
        assign w_a32 = {w_asum[g][W-1:0], (32-W)'(0)};
        spg_sine u_s (.i_clk(i_clk), .i_en(en), .i_phase(w_a32), .o_sin(w_sn[g]));
        spg_sine u_c (.i_clk(i_clk), .i_en(en), .i_phase(w_a32 + 32'h4000_0000),
                      .o_sin(w_cs[g]));
        // translation delay line to match the angle path
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_p1[g] <= w_psum[g]; r_p2[g] <= r_p1[g]; r_p3[g] <= r_p2[g];
                r_p4[g] <= r_p3[g]; r_p5[g] <= r_p4[g]; r_p6[g] <= r_p5[g];
                r_p7[g] <= r_p6[g];
            end
        end
    end

    // matrix products, stage 1
    logic signed [31:0] r_sr, r_cr, r_sp, r_cy_sp, r_sy_sp;
    logic signed [31:0] r_m0, r_sycr, r_sysr, r_m3, r_cycr, r_cysr, r_m7, r_m8;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sr <= w_sn[0]; r_cr <= w_cs[0]; r_sp <= w_sn[1];
            r_m0 <= 32'(spg_pkg::rnd30(64'(w_cs[2]) * 64'(w_cs[1])));
            r_cy_sp <= 32'(spg_pkg::rnd30(64'(w_cs[2]) * 64'(w_sn[1])));
            r_sy_sp <= 32'(spg_pkg::rnd30(64'(w_sn[2]) * 64'(w_sn[1])));
            r_sycr <= 32'(spg_pkg::rnd30(64'(w_sn[2]) * 64'(w_cs[0])));
            r_sysr <= 32'(spg_pkg::rnd30(64'(w_sn[2]) * 64'(w_sn[0])));
            r_m3 <= 32'(spg_pkg::rnd30(64'(w_sn[2]) * 64'(w_cs[1])));
            r_cycr <= 32'(spg_pkg::rnd30(64'(w_cs[2]) * 64'(w_cs[0])));
            r_cysr <= 32'(spg_pkg::rnd30(64'(w_cs[2]) * 64'(w_sn[0])));
            r_m7 <= 32'(spg_pkg::rnd30(64'(w_cs[1]) * 64'(w_sn[0])));
            r_m8 <= 32'(spg_pkg::rnd30(64'(w_cs[1]) * 64'(w_cs[0])));
        end
    end

    // stage 2: second-level products and sums
    logic signed [33:0] r_e [9];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e[0] <= 34'(r_m0);
            r_e[1] <= 34'(spg_pkg::rnd30(64'(r_cy_sp) * 64'(r_sr))) - 34'(r_sycr);
            r_e[2] <= 34'(spg_pkg::rnd30(64'(r_cy_sp) * 64'(r_cr))) + 34'(r_sysr);
            r_e[3] <= 34'(r_m3);
            r_e[4] <= 34'(spg_pkg::rnd30(64'(r_sy_sp) * 64'(r_sr))) + 34'(r_cycr);
            r_e[5] <= 34'(spg_pkg::rnd30(64'(r_sy_sp) * 64'(r_cr))) - 34'(r_cysr);
            r_e[6] <= -34'(r_sp);
            r_e[7] <= 34'(r_m7);
            r_e[8] <= 34'(r_m8);
        end
    end

    // stage 3: final rounding and clamp into output register
    logic signed [W-1:0] r_rot [9];
    logic signed [W-1:0] r_pos [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                logic signed [63:0] a, q;
                a = r_e[k][33] ? -64'(r_e[k]) : 64'(r_e[k]);
                q = (a + EHALF) >>> (31 - W);
                if (r_e[k][33]) q = -q;
                if (q > 64'(HI)) r_rot[k] <= HI[W-1:0];
                else if (q < 64'(LO)) r_rot[k] <= LO[W-1:0];
                else r_rot[k] <= q[W-1:0];
            end
            for (int k = 0; k < 3; k++) begin
                if (r_p7[k] > HI) r_pos[k] <= HI[W-1:0];
                else if (r_p7[k] < LO) r_pos[k] <= LO[W-1:0];
                else r_pos[k] <= r_p7[k][W-1:0];
            end
        end
    end

    assign o_rot_00 = r_rot[0]; assign o_rot_01 = r_rot[1]; assign o_rot_02 = r_rot[2];
    assign o_rot_10 = r_rot[3]; assign o_rot_11 = r_rot[4]; assign o_rot_12 = r_rot[5];
    assign o_rot_20 = r_rot[6]; assign o_rot_21 = r_rot[7]; assign o_rot_22 = r_rot[8];
    assign o_pos_x = r_pos[0]; assign o_pos_y = r_pos[1]; assign o_pos_z = r_pos[2];
endmodule
`default_nettype wire
